>>> hw/rtl/erp_pkg.sv
package erp_pkg;

	// block layout within a record
	localparam int BLOCK_BITS = 10;
	localparam logic [BLOCK_BITS-1:0] PAD_START = 10'd1020;

	// field accumulator
	localparam int ACC_W = 20;
	localparam logic [ACC_W-1:0] ACC_MAX = 20'hFFFFF;

	// configuration register widths and reset values
	localparam int MIN_W = 29;
	localparam int SCALE_W = 32;
	localparam int EPP_W = 11;
	localparam logic [MIN_W-1:0] MIN_RESET = 29'd0;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;
	localparam logic [EPP_W-1:0] EPP_RESET = 11'd1201;

	// register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_BLACK = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_EPP = 2'd2;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	// field queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW = 2;
	localparam int QCW = 3;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_DIGITS,
		PH_STOP
	} field_phase_t;

	typedef struct packed {
		logic [MIN_W-1:0]   black_q8;
		logic [SCALE_W-1:0] scale;
		logic [EPP_W-1:0]   epp;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] mag;
		logic             neg;
		logic             last;
	} field_item_t;

	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QCW-1:0] count;
	} queue_stat_t;

endpackage

>>> hw/rtl/erp_regs.sv
module erp_regs
	import erp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [MIN_W-1:0]   min_q;
	logic [SCALE_W-1:0] scale_q;
	logic [EPP_W-1:0]   epp_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= MIN_RESET;
			scale_q <= SCALE_RESET;
			epp_q   <= EPP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BLACK:    min_q <= pwdata[MIN_W-1:0];
				REG_SCALE:    scale_q <= pwdata;
				REG_EPP:      epp_q <= pwdata[EPP_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_BLACK:    prdata = {{(32-MIN_W){1'b0}}, min_q};
			REG_SCALE:    prdata = scale_q;
			REG_EPP:      prdata = {{(32-EPP_W){1'b0}}, epp_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg = '{black_q8: min_q, scale: scale_q, epp: epp_q};

endmodule

>>> hw/rtl/erp_front.sv
module erp_front
	import erp_pkg::*;
#(
	parameter int RECORD_BYTES = 8192,
	parameter int HEADER_BYTES = 144,
	parameter int FIELD_CHARS  = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ascii_byte,
	input  logic        record_start,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        push,
	output field_item_t item
);

	localparam int PW = $clog2(RECORD_BYTES);
	localparam int CW = $clog2(FIELD_CHARS + 1);
	localparam logic [PW-1:0] HDR = PW'(HEADER_BYTES);
	localparam logic [PW:0]   REC_END = (PW + 1)'(RECORD_BYTES);
	localparam logic [CW-1:0] FLD_END = CW'(FIELD_CHARS);

	logic [PW-1:0]    pos_q;
	logic [EPP_W-1:0] idx_q;
	logic [CW-1:0]    cnt_q;
	logic [ACC_W-1:0] acc_q;
	logic             neg_q;
	field_phase_t     ph_q;

	logic [PW-1:0]    pos_n;
	logic [EPP_W-1:0] idx_n;
	logic [CW-1:0]    cnt_n;
	logic [ACC_W-1:0] acc_n;
	logic             neg_n;
	field_phase_t     ph_n;

	logic [PW-1:0]    p;
	logic [EPP_W-1:0] idx;
	logic [CW-1:0]    cnt;
	logic [ACC_W-1:0] acc;
	logic             neg;
	field_phase_t     ph;

	logic [ACC_W-1:0] acc_t;
	logic             neg_t;
	field_phase_t     ph_t;
	logic             take_digit;
	logic [23:0]      acc_sum;
	logic [CW-1:0]    cnt_inc;
	logic [PW:0]      pos_inc;
	logic             active;
	logic             emit;
	logic             is_ws;
	logic             is_digit;
	logic             is_sign;
	logic             accept;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;
	assign push     = accept & emit;

	// character classes
	assign is_ws    = (ascii_byte == CH_SPACE) || (ascii_byte >= CH_TAB && ascii_byte <= CH_CR);
	assign is_digit = (ascii_byte >= CH_ZERO) && (ascii_byte <= CH_NINE);
	assign is_sign  = (ascii_byte == CH_PLUS) || (ascii_byte == CH_MINUS);

	// parse step for one beat
	always_comb begin
		// a record start resyncs everything before the byte is used
		p   = record_start ? '0 : pos_q;
		idx = record_start ? '0 : idx_q;
		cnt = record_start ? '0 : cnt_q;
		acc = record_start ? '0 : acc_q;
		neg = record_start ? 1'b0 : neg_q;
		ph  = record_start ? PH_SPACE : ph_q;

		active = (p >= HDR) && (p[BLOCK_BITS-1:0] < PAD_START) && (idx < cfg.epp);

		ph_t       = ph;
		neg_t      = neg;
		take_digit = 1'b0;
		case (ph)
			PH_SPACE: begin
				if (is_ws) begin
					ph_t = PH_SPACE;
				end else if (is_sign) begin
					neg_t = (ascii_byte == CH_MINUS);
					ph_t  = PH_DIGITS;
				end else if (is_digit) begin
					ph_t       = PH_DIGITS;
					take_digit = 1'b1;
				end else begin
					ph_t = PH_STOP;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					take_digit = 1'b1;
				end else begin
					ph_t = PH_STOP;
				end
			end
			default: ph_t = ph;
		endcase

		// acc*10 + digit, saturating
		acc_sum = 24'({acc, 3'b000}) + 24'({acc, 1'b0}) + 24'(ascii_byte[3:0]);
		if (!take_digit) begin
			acc_t = acc;
		end else if (acc_sum > 24'(ACC_MAX)) begin
			acc_t = ACC_MAX;
		end else begin
			acc_t = acc_sum[ACC_W-1:0];
		end

		cnt_inc = cnt + 1'b1;
		emit    = active && (cnt_inc >= FLD_END);

		idx_n = idx;
		cnt_n = cnt;
		acc_n = acc;
		neg_n = neg;
		ph_n  = ph;
		if (active) begin
			cnt_n = cnt_inc;
			acc_n = acc_t;
			neg_n = neg_t;
			ph_n  = ph_t;
		end
		if (emit) begin
			idx_n = idx + 1'b1;
			cnt_n = '0;
			acc_n = '0;
			neg_n = 1'b0;
			ph_n  = PH_SPACE;
		end

		// record end wraps as if a new record started
		pos_inc = {1'b0, p} + 1'b1;
		if (pos_inc >= REC_END) begin
			pos_n = '0;
			idx_n = '0;
			cnt_n = '0;
			acc_n = '0;
			neg_n = 1'b0;
			ph_n  = PH_SPACE;
		end else begin
			pos_n = pos_inc[PW-1:0];
		end

		item.mag  = acc_t;
		item.neg  = neg_t;
		item.last = (EPP_W'(idx + 1'b1) == cfg.epp);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			ph_q  <= PH_SPACE;
		end else if (accept) begin
			pos_q <= pos_n;
			idx_q <= idx_n;
			cnt_q <= cnt_n;
			acc_q <= acc_n;
			neg_q <= neg_n;
			ph_q  <= ph_n;
		end
	end

endmodule

>>> hw/rtl/erp_queue.sv
module erp_queue
	import erp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  field_item_t push_item,
	input  logic        pop,
	output field_item_t head,
	output queue_stat_t stat
);

	field_item_t    mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/erp_back.sv
module erp_back
	import erp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  field_item_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel,
	output logic        last_in_profile
);

	logic        v_s1, v_s2, v_s3;
	logic [29:0] mag_s1;
	logic        neg_s1, last_s1;
	logic [7:0]  q_s2;
	logic        neg_s2, last_s2;
	logic [7:0]  pix_s3;
	logic        last_s3;

	logic        adv1, adv2, adv3;
	logic [20:0] elev;
	logic [29:0] diff;
	logic [61:0] prod;

	// stall chain, output register last
	assign adv3 = ~v_s3 | out_ready;
	assign adv2 = ~v_s2 | adv3;
	assign adv1 = ~v_s1 | adv2;
	assign pop  = head_valid & adv1;

	// offset from black level in q8, then magnitude
	always_comb begin
		elev = head.neg ? (21'd0 - {1'b0, head.mag}) : {1'b0, head.mag};
		diff = {elev[20], elev, 8'h00} - {cfg.black_q8[MIN_W-1], cfg.black_q8};
	end

	assign prod = 62'(mag_s1) * 62'(cfg.scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= head_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mag_s1  <= diff[29] ? (30'd0 - diff) : diff;
			neg_s1  <= diff[29];
			last_s1 <= head.last;
		end
		// q24 product shifted down, low eight bits kept
		if (adv2) begin
			q_s2    <= prod[31:24];
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
		end
		// sign reapplied after truncation
		if (adv3) begin
			pix_s3  <= neg_s2 ? (8'd0 - q_s2) : q_s2;
			last_s3 <= last_s2;
		end
	end

	assign out_valid       = v_s3;
	assign pixel           = pix_s3;
	assign last_in_profile = last_s3;

endmodule

>>> hw/rtl/elevation_record_to_pixel_top.sv
// Elevation record to grey pixel converter. Takes one ASCII byte of an
// elevation profile record per beat, skips the record header and the pad
// bytes at the end of each 1024-byte block, parses fixed-width fields by atoi
// rules and produces one 8-bit pixel per field, (elevation - min) * scale
// truncated toward zero, with last_in_profile on the final counted field. A
// byte is accepted every cycle while the four-entry field queue has room;
// the parser updates its counters and accumulator in the cycle of the beat.
// A pixel leaves after its field's last byte once out_ready allows, passing
// through the field queue, the offset stage, the 30 x 32 multiplier and
// the output register. Sustained rate is one byte per cycle with out_ready
// held high. Registers: black level (signed q8) at 0x0, scale_q16 at 0x4,
// elevations_per_profile at 0x8; write only while no pixel is pending.
module elevation_record_to_pixel_top
	import erp_pkg::*;
#(
	parameter int RECORD_BYTES = 8192,
	parameter int HEADER_BYTES = 144,
	parameter int FIELD_CHARS  = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ascii_byte,
	input  logic              record_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        pixel,
	output logic              last_in_profile
);

	cfg_t        cfg;
	logic        push;
	logic        pop;
	field_item_t push_item;
	field_item_t head;
	queue_stat_t stat;

	erp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	erp_front #(
		.RECORD_BYTES (RECORD_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.FIELD_CHARS  (FIELD_CHARS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ascii_byte   (ascii_byte),
		.record_start (record_start),
		.cfg          (cfg),
		.q_full       (stat.full),
		.push         (push),
		.item         (push_item)
	);

	erp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	erp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.head_valid      (~stat.empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel           (pixel),
		.last_in_profile (last_in_profile)
	);

	// queue never overflows from the front
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("field pushed into full queue");

	// fill level tracks pushes and pops
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (stat.count == QCW'($past(stat.count) + 1'b1)))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (stat.count == QCW'($past(stat.count) - 1'b1)))
		else $error("queue count missed a pop");

endmodule
